// File: src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition never holds.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

`endif

// File: src/hdh_pkg.sv
// ----------------------------------------------------------------------------
// hdh_pkg
// Shared types and codes for the double-hashing key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package hdh_pkg;

  localparam int KEY_W  = 64;
  localparam int LEN_W  = 4;
  localparam int VAL_W  = 64;
  localparam int CFG_W  = 11;
  localparam int SLOT_W = 10;
  localparam int COL_W  = 32;
  localparam int KEY_BYTES = 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       hash_en;
    logic       div_start;
    logic       div_en;
    logic       probe_init;
    logic       rd_en;
    logic       probe_adv;
    logic       write;
    logic       col_inc;
    logic       capture;
    logic [1:0] res_code;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hash_done;
    logic div_last;
    logic op;
    logic used;
    logic match;
    logic last;
    logic wrap;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: src/hdh_in_if.sv
// ----------------------------------------------------------------------------
// hdh_in_if
// Request channel: operation, key and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdh_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [hdh_pkg::KEY_W-1:0]  key_bytes;
  logic [hdh_pkg::LEN_W-1:0]  key_length;
  logic [hdh_pkg::VAL_W-1:0]  value_in;

  modport source (output valid, opcode, key_bytes, key_length, value_in, input ready);
  modport sink   (input valid, opcode, key_bytes, key_length, value_in, output ready);
endinterface

`default_nettype wire

// File: src/hdh_out_if.sv
// ----------------------------------------------------------------------------
// hdh_out_if
// Response channel: status, value, slot and collision total.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdh_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [hdh_pkg::VAL_W-1:0]   value_out;
  logic [hdh_pkg::SLOT_W-1:0]  slot_index;
  logic [hdh_pkg::COL_W-1:0]   collision_count;

  modport source (output valid, status, value_out, slot_index, collision_count,
                  input ready);
  modport sink   (input valid, status, value_out, slot_index, collision_count,
                  output ready);
endinterface

`default_nettype wire

// File: src/hdh_dp.sv
// ----------------------------------------------------------------------------
// hdh_dp
// Datapath: hashing, bit-serial remainders, probe address, slot memory,
// collision total and response register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hdh_dp #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int MAX_KEY_BYTES = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [hdh_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         in_opcode,
  input  wire logic [hdh_pkg::KEY_W-1:0]    in_key,
  input  wire logic [hdh_pkg::LEN_W-1:0]    in_len,
  input  wire logic [hdh_pkg::VAL_W-1:0]    in_value,
  input  wire hdh_pkg::cmd_t                cmd,
  output hdh_pkg::sts_t                     sts,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic [hdh_pkg::VAL_W-1:0]         out_value,
  output logic [hdh_pkg::SLOT_W-1:0]        out_slot,
  output logic [hdh_pkg::COL_W-1:0]         out_col
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW  = $clog2(TABLE_DEPTH + 1);
  localparam int RW  = SW + 1;
  localparam int CW  = (SW > hdh_pkg::CFG_W) ? SW : hdh_pkg::CFG_W;
  localparam int MW  = 1 + hdh_pkg::LEN_W + hdh_pkg::KEY_W + hdh_pkg::VAL_W;
  localparam int HW  = 64;
  localparam int DCW = $clog2(HW);

  logic [hdh_pkg::CFG_W-1:0]   table_size;
  logic                        op;
  logic [hdh_pkg::KEY_W-1:0]   key;
  logic [hdh_pkg::LEN_W-1:0]   len;
  logic [hdh_pkg::VAL_W-1:0]   value;
  logic [SW-1:0]               size;
  logic [hdh_pkg::KEY_W-1:0]   hkey;
  logic [hdh_pkg::LEN_W-1:0]   hcnt;
  logic [HW-1:0]               h1;
  logic [HW-1:0]               h2;
  logic [DCW-1:0]              dcnt;
  logic [RW-1:0]               r1;
  logic [RW-1:0]               r2;
  logic [AW-1:0]               start;
  logic [AW-1:0]               step;
  logic [AW-1:0]               idx;
  logic [SW-1:0]               pcnt;
  logic [AW-1:0]               clr_addr;
  logic [MW-1:0]               mem [TABLE_DEPTH];
  logic [MW-1:0]               rdata;
  logic [hdh_pkg::COL_W-1:0]   col;

  logic [CW-1:0]               tsz_ext;
  logic [SW-1:0]               size_eff;
  logic [hdh_pkg::LEN_W-1:0]   len_c;
  logic [hdh_pkg::KEY_W-1:0]   key_m;
  logic [HW-1:0]               bsx;
  logic [RW-1:0]               r1_sh;
  logic [RW-1:0]               r2_sh;
  logic [RW-1:0]               d1;
  logic [RW-1:0]               d2;
  logic [AW:0]                 idx_sum;
  logic [AW-1:0]               idx_nxt;
  logic                        rd_used;
  logic [hdh_pkg::LEN_W-1:0]   rd_len;
  logic [hdh_pkg::KEY_W-1:0]   rd_key;
  logic [hdh_pkg::VAL_W-1:0]   rd_val;

  always_comb begin
    tsz_ext = CW'(table_size);
    if (tsz_ext < CW'(2)) begin
      size_eff = SW'(2);
    end else if (tsz_ext > CW'(TABLE_DEPTH)) begin
      size_eff = SW'(TABLE_DEPTH);
    end else begin
      size_eff = SW'(tsz_ext);
    end
    len_c = (in_len > hdh_pkg::LEN_W'(MAX_KEY_BYTES)) ?
            hdh_pkg::LEN_W'(MAX_KEY_BYTES) : in_len;
    for (int j = 0; j < hdh_pkg::KEY_BYTES; j++) begin
      key_m[8*j +: 8] = (hdh_pkg::LEN_W'(j) < len_c) ? in_key[8*j +: 8] : 8'd0;
    end
  end

  assign bsx   = {{(HW-8){hkey[7]}}, hkey[7:0]};
  assign d1    = RW'(size);
  assign d2    = RW'(size) - RW'(1);
  assign r1_sh = {r1[RW-2:0], h1[HW-1]};
  assign r2_sh = {r2[RW-2:0], h2[HW-1]};

  assign idx_sum = {1'b0, idx} + {1'b0, step};
  assign idx_nxt = ((AW+1 > SW ? idx_sum : (AW+1)'(idx_sum)) >= (AW+1)'(size)) ?
                   AW'(idx_sum - (AW+1)'(size)) : AW'(idx_sum);

  assign {rd_used, rd_len, rd_key, rd_val} = rdata;

  always_comb begin
    sts.clear_done = (clr_addr == AW'(TABLE_DEPTH - 1));
    sts.hash_done  = (hcnt == len);
    sts.div_last   = (dcnt == DCW'(HW - 1));
    sts.op         = op;
    sts.used       = rd_used;
    sts.match      = rd_used && (rd_len == len) && (rd_key == key);
    sts.last       = (pcnt == size - SW'(1));
    sts.wrap       = (idx_nxt == start);
    sts.out_busy   = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= hdh_pkg::CFG_W'(1021);
    end else if (cfg_we) begin
      table_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_opcode;
      key   <= key_m;
      len   <= len_c;
      value <= in_value;
      size  <= size_eff;
      hkey  <= key_m;
      hcnt  <= '0;
      h1    <= '0;
      h2    <= '0;
    end else if (cmd.hash_en) begin
      h1   <= (h1 << 5) - h1 + bsx;
      h2   <= (h2 << 5) + (h2 << 2) + h2 + bsx;
      hkey <= hkey >> 8;
      hcnt <= hcnt + hdh_pkg::LEN_W'(1);
    end else if (cmd.div_en) begin
      h1 <= h1 << 1;
      h2 <= h2 << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      r1   <= '0;
      r2   <= '0;
      dcnt <= '0;
    end else if (cmd.div_en) begin
      r1   <= (r1_sh >= d1) ? r1_sh - d1 : r1_sh;
      r2   <= (r2_sh >= d2) ? r2_sh - d2 : r2_sh;
      dcnt <= dcnt + DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      start <= AW'(r1);
      step  <= AW'(r2) + AW'(1);
      idx   <= AW'(r1);
      pcnt  <= '0;
    end else if (cmd.probe_adv) begin
      idx  <= idx_nxt;
      pcnt <= pcnt + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= '0;
    end else if (cmd.write) begin
      mem[idx] <= {1'b1, len, key, value};
    end
    if (cmd.rd_en) begin
      rdata <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (cmd.col_inc && (col != '1)) begin
      col <= col + hdh_pkg::COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_status <= cmd.res_code;
      out_value  <= (cmd.res_code == hdh_pkg::ST_FOUND) ? rd_val : '0;
      out_slot   <= ((cmd.res_code == hdh_pkg::ST_FOUND) ||
                     (cmd.res_code == hdh_pkg::ST_INSERTED)) ?
                    hdh_pkg::SLOT_W'(idx) : '0;
      out_col    <= col;
    end
  end

  `ASSERT_IMPL(a_probe_in_range, clk, rst, cmd.rd_en, idx < AW'(size - SW'(1)) || idx == AW'(size - SW'(1)))
  `ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.capture, !out_valid || out_ready)
  `ASSERT_IMPL(a_valid_from_capture, clk, rst, $rose(out_valid), $past(cmd.capture))

endmodule

`default_nettype wire

// File: src/hdh_ctrl.sv
// ----------------------------------------------------------------------------
// hdh_ctrl
// Sequencer: clear sweep, hashing, remainders, probe walk and response.
// ----------------------------------------------------------------------------
`default_nettype none

module hdh_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire hdh_pkg::sts_t  sts,
  output hdh_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_DIV, S_PINIT, S_PRD, S_PCHK, S_DONE
  } state_t;

  state_t     state, state_next;
  logic [1:0] res_code, res_code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    cmd           = '0;
    cmd.res_code  = res_code;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.hash_done) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.hash_en = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (sts.div_last) state_next = S_PINIT;
      end
      S_PINIT: begin
        cmd.probe_init = 1'b1;
        state_next     = S_PRD;
      end
      S_PRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        if (sts.op == hdh_pkg::OP_INSERT) begin
          if (!sts.used) begin
            cmd.write     = 1'b1;
            res_code_next = hdh_pkg::ST_INSERTED;
            state_next    = S_DONE;
          end else begin
            cmd.col_inc = 1'b1;
            if (sts.last) begin
              res_code_next = hdh_pkg::ST_FULL;
              state_next    = S_DONE;
            end else begin
              cmd.probe_adv = 1'b1;
              state_next    = S_PRD;
            end
          end
        end else begin
          if (sts.match) begin
            res_code_next = hdh_pkg::ST_FOUND;
            state_next    = S_DONE;
          end else if (!sts.used || sts.last || sts.wrap) begin
            res_code_next = hdh_pkg::ST_NOT_FOUND;
            state_next    = S_DONE;
          end else begin
            cmd.probe_adv = 1'b1;
            state_next    = S_PRD;
          end
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      res_code <= hdh_pkg::ST_NOT_FOUND;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

endmodule

`default_nettype wire

// File: src/hash_table_double_hashing.sv
// ----------------------------------------------------------------------------
// hash_table_double_hashing
// Open-addressing key/value table with double hashing.
//
//   channel  dir  handshake     content
//   req      in   valid/ready   opcode, key_bytes, key_length, value_in
//   rsp      out  valid/ready   status, value_out, slot_index, collision_count
//   cfg      in   cfg_we        table_size
//
// One transaction at a time: accept, hash key_length bytes (capped at
// MAX_KEY_BYTES), bit-serial remainders of both 64-bit hashes, probe setup,
// then per probe a slot memory read then a check, and finally a load of the
// response register.
// After reset a clearing sweep over all TABLE_DEPTH slots runs before req.ready.
// A response waiting on rsp does not block the next request; it stalls only
// the completion of the following one.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_table_double_hashing #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int MAX_KEY_BYTES = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  hdh_in_if.sink                          req,
  hdh_out_if.source                       rsp,
  input  wire logic                       cfg_we,
  input  wire logic [hdh_pkg::CFG_W-1:0]  cfg_data
);

  hdh_pkg::cmd_t cmd;
  hdh_pkg::sts_t sts;
  logic          ready;

  assign req.ready = ready;

  hdh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hdh_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_opcode  (req.opcode),
    .in_key     (req.key_bytes),
    .in_len     (req.key_length),
    .in_value   (req.value_in),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_value  (rsp.value_out),
    .out_slot   (rsp.slot_index),
    .out_col    (rsp.collision_count)
  );

endmodule

`default_nettype wire

// File: sim/hash_table_double_hashing_tb.sv
// ----------------------------------------------------------------------------
// hash_table_double_hashing_tb
// Drives insert and search transactions at the double-hashing table through
// several table sizes, predicts every response with a model of the table, and
// checks each response field by field under random idling on both channels in all but the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hash_table_double_hashing_tb;

  localparam int DEPTH = 1024;

  typedef struct packed {
    logic [1:0]                 status;
    logic [hdh_pkg::VAL_W-1:0]  value;
    logic [hdh_pkg::SLOT_W-1:0] slot;
    logic [hdh_pkg::COL_W-1:0]  collisions;
  } resp_t;

  int errors = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  class table_scoreboard;
    logic [63:0] keys [DEPTH];
    logic [3:0]  lens [DEPTH];
    logic [63:0] vals [DEPTH];
    bit          used [DEPTH];
    logic [31:0] col_total;
    int          size_reg;
    resp_t       pending [$];

    function new();
      for (int i = 0; i < DEPTH; i++) used[i] = 0;
      col_total = 0;
      size_reg = 1021;
    endfunction

    function automatic logic [63:0] poly(input logic [63:0] k, input int n,
                                         input logic [63:0] m);
      logic [63:0] h;
      h = '0;
      for (int i = 0; i < n; i++) h = h * m + {{56{k[8*i+7]}}, k[8*i +: 8]};
      return h;
    endfunction

    function automatic void note_request(input logic op, input logic [63:0] key_in,
                                         input logic [3:0] len_in, input logic [63:0] val);
      logic [63:0] key, start, stp, idx, size;
      int n;
      resp_t r;
      size = size_reg < 2 ? 64'd2 : (size_reg > DEPTH ? 64'(DEPTH) : 64'(size_reg));
      n = len_in > 4'd8 ? 8 : int'(len_in);
      key = key_in;
      if (n < 8) key = key & ((64'd1 << (8 * n)) - 64'd1);
      start = poly(key, n, 64'd31) % size;
      stp = 64'd1 + poly(key, n, 64'd37) % (size - 64'd1);
      r = '0;
      r.status = hdh_pkg::ST_NOT_FOUND;
      if (op == hdh_pkg::OP_INSERT) begin
        r.status = hdh_pkg::ST_FULL;
        for (longint i = 0; i < size; i++) begin
          idx = (start + 64'(i) * stp) % size;
          if (used[idx]) begin
            if (col_total != 32'hFFFF_FFFF) col_total++;
            continue;
          end
          keys[idx] = key; lens[idx] = 4'(n); vals[idx] = val; used[idx] = 1;
          r.status = hdh_pkg::ST_INSERTED;
          r.slot = hdh_pkg::SLOT_W'(idx);
          break;
        end
      end else begin
        idx = start;
        for (longint i = 0; i < size; i++) begin
          if (!used[idx]) break;
          if (lens[idx] == 4'(n) && keys[idx] == key) begin
            r.status = hdh_pkg::ST_FOUND; r.value = vals[idx];
            r.slot = hdh_pkg::SLOT_W'(idx);
            break;
          end
          idx = (start + 64'(i + 1) * stp) % size;
          if (idx == start) break;
        end
      end
      r.collisions = col_total;
      pending = {pending, r};
    endfunction

    task automatic check_response(input resp_t got);
      resp_t w;
      if (pending.size() == 0) begin
        report("unexpected response", 64'(got.status), 64'd0);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) report("status", 64'(got.status), 64'(w.status));
      if (got.value !== w.value) report("value_out", got.value, w.value);
      if (got.slot !== w.slot) report("slot_index", 64'(got.slot), 64'(w.slot));
      if (got.collisions !== w.collisions)
        report("collision_count", 64'(got.collisions), 64'(w.collisions));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [hdh_pkg::CFG_W-1:0] cfg_data = '0;
  bit idle_on = 1;

  hdh_in_if  req();
  hdh_out_if rsp();

  hash_table_double_hashing uut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  table_scoreboard sb = new();
  logic [63:0] used_keys [$];
  logic [3:0]  used_lens [$];

  initial begin
    req.valid = 0; req.opcode = hdh_pkg::OP_INSERT; req.key_bytes = '0;
    req.key_length = '0; req.value_in = '0;
    rsp.ready = 0;
  end

  // response side: random stall bursts, accepted transactions checked
  initial begin
    resp_t r;
    repeat (3) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        r.status = rsp.status; r.value = rsp.value_out;
        r.slot = rsp.slot_index; r.collisions = rsp.collision_count;
        sb.check_response(r);
      end
    end
  end

  task automatic send(input logic op, input logic [63:0] key, input logic [3:0] len,
                      input logic [63:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req.valid <= 1; req.opcode <= op; req.key_bytes <= key;
    req.key_length <= len; req.value_in <= val;
    do @(posedge clk); while (!req.ready);
    sb.note_request(op, key, len, val);
    if (op == hdh_pkg::OP_INSERT) begin
      used_keys = {used_keys, key}; used_lens = {used_lens, len};
    end
  endtask

  task automatic drain();
    req.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_size(input logic [hdh_pkg::CFG_W-1:0] s);
    cfg_we <= 1; cfg_data <= s;
    @(posedge clk);
    cfg_we <= 0;
    sb.size_reg = int'(s);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0 || used_keys.size() == 0)
        send(hdh_pkg::OP_INSERT,
             (rnd64() & (64'hFF << (8 * $urandom_range(0, 7)))) | (rnd64() % 64'd5),
             4'($urandom_range(0, 15)), rnd64());
      else if ($urandom_range(0, 3) != 0) begin
        k = int'($urandom_range(0, used_keys.size() - 1));
        send(hdh_pkg::OP_SEARCH,
             used_keys[k] | ((rnd64() << 32) & {64{used_lens[k] < 4'd4}}),
             used_lens[k], rnd64());
      end else
        send(hdh_pkg::OP_SEARCH, rnd64(), 4'($urandom_range(0, 15)), rnd64());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    // directed: tiny table, extremes, full table
    set_size(11'd0);
    send(hdh_pkg::OP_INSERT, '0, 4'd0, '1);
    send(hdh_pkg::OP_SEARCH, '0, 4'd0, '0);
    send(hdh_pkg::OP_INSERT, '1, 4'd15, 64'h0123_4567_89AB_CDEF);
    send(hdh_pkg::OP_INSERT, 64'h80, 4'd1, 64'd5);
    send(hdh_pkg::OP_SEARCH, '1, 4'd8, '0);
    send(hdh_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_FF80, 4'd1, '0);
    send(hdh_pkg::OP_SEARCH, 64'h7F, 4'd1, '0);
    drain();
    set_size(11'd2047);
    send(hdh_pkg::OP_INSERT, 64'h4142_4344, 4'd4, 64'hAAAA);
    send(hdh_pkg::OP_INSERT, 64'h4142_4344, 4'd4, 64'hBBBB);
    send(hdh_pkg::OP_SEARCH, 64'hFFFF_0000_4142_4344, 4'd4, '1);
    send(hdh_pkg::OP_SEARCH, 64'h4142_4344, 4'd3, '0);
    send(hdh_pkg::OP_SEARCH, 64'h4142_4344, 4'd5, '0);
    send(hdh_pkg::OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 4'd8, '0);
    drain();
    set_size(11'd3);
    for (int i = 0; i < 5; i++) send(hdh_pkg::OP_INSERT, 64'(i), 4'd1, 64'(i));
    send(hdh_pkg::OP_SEARCH, 64'd9, 4'd1, 64'd0);
    drain();
    // random phases over several sizes
    set_size(11'd1021); random_phase(300); drain();
    set_size(11'd7);    random_phase(150); drain();
    set_size(11'd1024); random_phase(200); drain();
    set_size(11'd31);   random_phase(150); drain();
    idle_on = 0;
    set_size(11'd1);    random_phase(180);
    drain();
    if (errors == 0)
      $display("hash_table_double_hashing_tb: done, clean");
    else
      $display("hash_table_double_hashing_tb: done, errors");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("hash_table_double_hashing_tb: done, errors");
    $finish;
  end

endmodule

// File: hash_table_double_hashing.f
+incdir+src
src/hdh_pkg.sv
src/hdh_in_if.sv
src/hdh_out_if.sv
src/hdh_dp.sv
src/hdh_ctrl.sv
src/hash_table_double_hashing.sv
sim/hash_table_double_hashing_tb.sv
